[hdl/elcr_pkg.sv]
// shared constants and widths for the edge length constraint relaxer
package elcr_pkg;

    // default configuration of the top level
    localparam int NODE_COUNT_DEF  = 64;
    localparam int COORD_BITS_DEF  = 24;

    // fixed field widths
    localparam int NODE_W    = 6;
    localparam int POS_W     = 24;
    localparam int DELTA_W   = 24;
    localparam int REST_W    = 23;
    localparam int TOL_W     = 21;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 1'b1;

    // register reset values
    localparam logic [REST_W-1:0] REST_RESET = 23'd209715;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 21'd0;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RELAX = 1'b1;

    // internal arithmetic widths
    localparam int SCALE_BITS = 25;              // scaled magnitudes stay below 2^25
    localparam int SC_W       = SCALE_BITS + 1;  // signed scaled component
    localparam int SQ_W       = 2 * SCALE_BITS;  // one squared component
    localparam int SUM_W      = SQ_W + 2;        // sum of three squares
    localparam int ROOT_W     = SUM_W / 2;       // integer square root
    localparam int QUOT_W     = DELTA_W;         // move magnitude never exceeds |delta|
    localparam int PROD_W     = QUOT_W + DELTA_W; // |delta| * |component| < 2^48
    localparam int MOVE_W     = QUOT_W + 1;

    localparam logic signed [DELTA_W-1:0] DELTA_MAX = 24'sh7FFFFF;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = 24'sh800000;

endpackage

[hdl/elcr_ifs.sv]
// word channels of the edge length constraint relaxer

interface elcr_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      op;
    logic        [elcr_pkg::NODE_W-1:0]        node_a;
    logic        [elcr_pkg::NODE_W-1:0]        node_b;
    logic signed [elcr_pkg::POS_W-1:0]         pos_x;
    logic signed [elcr_pkg::POS_W-1:0]         pos_y;
    logic signed [elcr_pkg::POS_W-1:0]         pos_z;

    modport source (output valid, op, node_a, node_b, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, op, node_a, node_b, pos_x, pos_y, pos_z, output ready);
endinterface

interface elcr_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [elcr_pkg::DELTA_W-1:0]       delta;
    logic                                      not_converged;

    modport source (output valid, delta, not_converged, input ready);
    modport sink   (input valid, delta, not_converged, output ready);
endinterface

[hdl/edge_length_constraint_relaxer_unit.sv]
// top level of the edge length constraint relaxer
//
// keeps NODE_COUNT 3-d node positions (signed q4.20, COORD_BITS per axis) in one
// ram word per node. a write word (op = 0) stores one node as it is accepted and
// the unit is ready again on the next cycle. a relax word (op = 1) reads both
// nodes, forms the distance by an iterative square root, halves the shortfall to
// rest_length into delta, moves both nodes along the unit direction by delta
// (three divider lanes working side by side) and writes them back before the
// next word is taken, so edges that share a node always see fresh positions.
// a relax word runs through the accept, the two ram reads, the root unit
// (26 steps), the divider lanes (24 steps), the two ram writes and the stages
// around them before the next accept. a zero-length edge skips the divider and
// the writes. a stalled result register adds its stall to the relax word that
// follows. one result word (delta, not_converged) leaves per relax word through
// an output register, so the next word can start while a result waits. a
// zero-length edge still yields its result word but leaves the nodes alone.
// node indexes wrap modulo NODE_COUNT; nodes never written read as anything.
module edge_length_constraint_relaxer_unit #(
    parameter int NODE_COUNT = elcr_pkg::NODE_COUNT_DEF,
    parameter int COORD_BITS = elcr_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    elcr_in_if.sink                           in_ch,
    elcr_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [elcr_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [elcr_pkg::CFG_W-1:0]        cfg_wdata
);

    // index and arithmetic widths
    localparam int IW        = $clog2(NODE_COUNT);
    localparam int DW        = COORD_BITS + 1;                          // coordinate difference
    localparam int LW        = (DW > elcr_pkg::SC_W) ? DW : elcr_pkg::SC_W;
    localparam int SHIFT_MAX = (DW > elcr_pkg::SCALE_BITS) ? DW - elcr_pkg::SCALE_BITS : 0;
    localparam int SW        = (SHIFT_MAX > 0) ? $clog2(SHIFT_MAX + 1) : 1;
    localparam int DIST_W    = elcr_pkg::ROOT_W + SHIFT_MAX;
    localparam int DIFF_W    = DIST_W + 2;
    localparam int EW        = ((COORD_BITS > elcr_pkg::MOVE_W) ? COORD_BITS
                                                               : elcr_pkg::MOVE_W) + 2;
    localparam int MW        = 3 * COORD_BITS;                          // ram word: x, y, z

    localparam logic [LW-1:0] SCALE_LIMIT = LW'(1) << elcr_pkg::SCALE_BITS;
    localparam logic signed [EW-1:0] CMAX = EW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] CMIN = -CMAX - EW'(1);
    localparam logic signed [DIFF_W-1:0] DMAX_X = DIFF_W'(elcr_pkg::DELTA_MAX);
    localparam logic signed [DIFF_W-1:0] DMIN_X = DIFF_W'(elcr_pkg::DELTA_MIN);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDB   = 4'd1;
    localparam logic [3:0] S_DIFF  = 4'd2;
    localparam logic [3:0] S_SCALE = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_DELTA = 4'd7;
    localparam logic [3:0] S_PROD  = 4'd8;
    localparam logic [3:0] S_DIVGO = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_WA    = 4'd11;
    localparam logic [3:0] S_WB    = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [EW-1:0] v);
        if (v > CMAX)
        begin
            return COORD_BITS'(CMAX);
        end
        else if (v < CMIN)
        begin
            return COORD_BITS'(CMIN);
        end
        return COORD_BITS'(v);
    endfunction

    // configuration registers
    logic [elcr_pkg::REST_W-1:0] rest_reg;
    logic [elcr_pkg::TOL_W-1:0]  tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg <= elcr_pkg::REST_RESET;
            tol_reg  <= elcr_pkg::TOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                elcr_pkg::REG_REST_LENGTH: rest_reg <= cfg_wdata[elcr_pkg::REST_W-1:0];
                elcr_pkg::REG_TOLERANCE:   tol_reg  <= cfg_wdata[elcr_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // node index wrap, worked out at elaboration
    logic [IW-1:0] wrap_tab [2**elcr_pkg::NODE_W];

    for (genvar i = 0; i < 2**elcr_pkg::NODE_W; i++)
    begin : g_wrap
        assign wrap_tab[i] = IW'(i % NODE_COUNT);
    end

    // sequencer and datapath registers
    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic [IW-1:0] a_idx_reg;
    logic [IW-1:0] b_idx_reg;
    logic signed [COORD_BITS-1:0]         pa_reg   [3];
    logic signed [COORD_BITS-1:0]         pb_reg   [3];
    logic signed [DW-1:0]                 d_reg    [3];
    logic signed [elcr_pkg::SC_W-1:0]     sk_reg   [3];
    logic [elcr_pkg::SCALE_BITS-1:0]      smag_reg [3];
    logic                                 sneg_reg [3];
    logic [elcr_pkg::SQ_W-1:0]            sq_reg   [3];
    logic [elcr_pkg::PROD_W-1:0]          prod_reg [3];
    logic signed [elcr_pkg::MOVE_W-1:0]   move_reg [3];
    logic [SW-1:0]                        s_reg;
    logic [elcr_pkg::ROOT_W-1:0]          root_reg;
    logic signed [elcr_pkg::DELTA_W-1:0]  delta_reg;
    logic                                 flag_reg;

    logic                                 out_valid_reg;
    logic signed [elcr_pkg::DELTA_W-1:0]  out_delta_reg;
    logic                                 out_flag_reg;

    // ram
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [MW-1:0]     ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [MW-1:0]     ram_rdata;

    elcr_ram #(
        .WIDTH (MW),
        .DEPTH (NODE_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // root unit and divider lanes
    logic                          sqrt_done;
    logic [elcr_pkg::ROOT_W-1:0]   sqrt_root;
    logic [elcr_pkg::SUM_W-1:0]    sum_c;
    logic                          div_done   [3];
    logic [elcr_pkg::QUOT_W-1:0]   div_quot   [3];

    elcr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SUM),
        .radicand (sum_c),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        elcr_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (state_reg == S_DIVGO),
            .dividend (prod_reg[k]),
            .divisor  (root_reg),
            .done     (div_done[k]),
            .quot     (div_quot[k])
        );
    end

    // handshakes
    logic in_acc;
    logic out_load;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_load    = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.delta         = out_delta_reg;
    assign out_ch.not_converged = out_flag_reg;

    // combinational datapath pieces
    logic signed [COORD_BITS-1:0]        rd_c     [3];
    logic signed [LW-1:0]                dx_c     [3];
    logic [LW-1:0]                       mag_c    [3];
    logic [LW-1:0]                       mmax_c;
    logic [SW-1:0]                       s_c;
    logic [elcr_pkg::SCALE_BITS-1:0]     smag_c   [3];
    logic signed [2*elcr_pkg::SC_W-1:0]  sq_full  [3];
    logic [DIST_W-1:0]                   dist_c;
    logic signed [DIFF_W-1:0]            diff_c;
    logic signed [DIFF_W-1:0]            half_c;
    logic signed [elcr_pkg::DELTA_W-1:0] delta_c;
    logic [elcr_pkg::DELTA_W-1:0]        dmag_c;
    logic [elcr_pkg::PROD_W+1:0]         prod_full[3];
    logic signed [COORD_BITS-1:0]        na_c     [3];
    logic signed [COORD_BITS-1:0]        nb_c     [3];
    logic signed [COORD_BITS-1:0]        wr_c     [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rd_c[k] = ram_rdata[k*COORD_BITS +: COORD_BITS];
        end

        // magnitudes and the shift that brings them under the root unit's range
        mmax_c = '0;
        for (int k = 0; k < 3; k++)
        begin
            dx_c[k]  = LW'(d_reg[k]);
            mag_c[k] = dx_c[k][LW-1] ? LW'(-dx_c[k]) : LW'(dx_c[k]);
            if (mag_c[k] > mmax_c)
            begin
                mmax_c = mag_c[k];
            end
        end
        s_c = '0;
        for (int k = SHIFT_MAX; k >= 0; k--)
        begin
            if ((mmax_c >> k) < SCALE_LIMIT)
            begin
                s_c = SW'(k);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            smag_c[k] = elcr_pkg::SCALE_BITS'(mag_c[k] >> s_c);
            sq_full[k] = sk_reg[k] * sk_reg[k];
        end

        sum_c = elcr_pkg::SUM_W'(sq_reg[0]) + elcr_pkg::SUM_W'(sq_reg[1])
              + elcr_pkg::SUM_W'(sq_reg[2]);

        // distance, shortfall and the halved delta, rounded toward zero
        dist_c = DIST_W'(root_reg) << s_reg;
        diff_c = $signed(DIFF_W'(rest_reg)) - $signed(DIFF_W'(dist_c));
        half_c = (diff_c + $signed({{(DIFF_W-1){1'b0}}, diff_c[DIFF_W-1]})) >>> 1;
        if (half_c > DMAX_X)
        begin
            delta_c = elcr_pkg::DELTA_MAX;
        end
        else if (half_c < DMIN_X)
        begin
            delta_c = elcr_pkg::DELTA_MIN;
        end
        else
        begin
            delta_c = elcr_pkg::DELTA_W'(half_c);
        end

        // |delta| * |component|, sign handled apart from the divider
        dmag_c = delta_reg[elcr_pkg::DELTA_W-1] ? elcr_pkg::DELTA_W'(-delta_reg)
                                               : elcr_pkg::DELTA_W'(delta_reg);
        for (int k = 0; k < 3; k++)
        begin
            prod_full[k] = dmag_c * smag_reg[k];
            na_c[k] = sat_coord(EW'(pa_reg[k]) + EW'(move_reg[k]));
            nb_c[k] = sat_coord(EW'(pb_reg[k]) - EW'(move_reg[k]));
        end

        wr_c[0] = sat_coord(EW'(in_ch.pos_x));
        wr_c[1] = sat_coord(EW'(in_ch.pos_y));
        wr_c[2] = sat_coord(EW'(in_ch.pos_z));
    end

    // ram port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = a_idx_reg;
        ram_wdata = {wr_c[2], wr_c[1], wr_c[0]};
        ram_raddr = b_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = wrap_tab[in_ch.node_a];
                ram_waddr = wrap_tab[in_ch.node_a];
                ram_we    = in_acc && (in_ch.op == elcr_pkg::OP_WRITE);
            end
            S_WA:
            begin
                ram_we    = 1'b1;
                ram_wdata = {na_c[2], na_c[1], na_c[0]};
            end
            S_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = b_idx_reg;
                ram_wdata = {nb_c[2], nb_c[1], nb_c[0]};
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (in_ch.op == elcr_pkg::OP_RELAX))
                begin
                    state_next = S_RDB;
                end
            end
            S_RDB:   state_next = S_DIFF;
            S_DIFF:  state_next = S_SCALE;
            S_SCALE: state_next = S_SQ;
            S_SQ:    state_next = S_SUM;
            S_SUM:   state_next = S_ROOT;
            S_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = S_DELTA;
                end
            end
            S_DELTA:
            begin
                // zero-length edge: result only, nodes stay put
                state_next = (root_reg == '0) ? S_OUT : S_PROD;
            end
            S_PROD:  state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done[0])
                begin
                    state_next = S_WA;
                end
            end
            S_WA:    state_next = S_WB;
            S_WB:    state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_idx_reg <= wrap_tab[in_ch.node_a];
            b_idx_reg <= wrap_tab[in_ch.node_b];
        end
        if (state_reg == S_RDB)
        begin
            pa_reg <= rd_c;
        end
        if (state_reg == S_DIFF)
        begin
            pb_reg <= rd_c;
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k] <= DW'(pa_reg[k]) - DW'(rd_c[k]);
            end
        end
        if (state_reg == S_SCALE)
        begin
            s_reg <= s_c;
            for (int k = 0; k < 3; k++)
            begin
                smag_reg[k] <= smag_c[k];
                sneg_reg[k] <= dx_c[k][LW-1];
                sk_reg[k]   <= dx_c[k][LW-1] ? -$signed({1'b0, smag_c[k]})
                                             : $signed({1'b0, smag_c[k]});
            end
        end
        if (state_reg == S_SQ)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= sq_full[k][elcr_pkg::SQ_W-1:0];
            end
        end
        if ((state_reg == S_ROOT) && sqrt_done)
        begin
            root_reg <= sqrt_root;
        end
        if (state_reg == S_DELTA)
        begin
            delta_reg <= delta_c;
            flag_reg  <= diff_c > $signed(DIFF_W'(tol_reg));
        end
        if (state_reg == S_PROD)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= prod_full[k][elcr_pkg::PROD_W-1:0];
            end
        end
        if ((state_reg == S_DIV) && div_done[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                move_reg[k] <= (delta_reg[elcr_pkg::DELTA_W-1] ^ sneg_reg[k])
                             ? -$signed({1'b0, div_quot[k]})
                             : $signed({1'b0, div_quot[k]});
            end
        end
        if (out_load)
        begin
            out_delta_reg <= delta_reg;
            out_flag_reg  <= flag_reg;
        end
    end

endmodule

[hdl/elcr_ram.sv]
// generic single-write, single-read ram with registered read data
module elcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/elcr_sqrt.sv]
// iterative integer square root, one result bit per cycle
module elcr_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [elcr_pkg::SUM_W-1:0]    radicand,
    output logic                          done,
    output logic [elcr_pkg::ROOT_W-1:0]   root
);

    localparam int RW = elcr_pkg::ROOT_W;
    localparam int SW = elcr_pkg::SUM_W;
    localparam int CW = $clog2(RW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] rad_reg;
    logic [RW:0]   rem_reg;
    logic [RW-1:0] root_reg;

    logic [RW+2:0] rem_t;
    logic [RW+2:0] trial;
    logic          ge;

    always_comb
    begin
        rem_t = {rem_reg, rad_reg[SW-1 -: 2]};
        trial = (RW + 3)'({root_reg, 2'b01});
        ge    = rem_t >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(RW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SW-3:0], 2'b00};
            rem_reg  <= ge ? (RW + 1)'(rem_t - trial) : (RW + 1)'(rem_t);
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hdl/elcr_div.sv]
// restoring divider lane, one quotient bit per cycle
module elcr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [elcr_pkg::PROD_W-1:0]   dividend,
    input  logic [elcr_pkg::ROOT_W-1:0]   divisor,
    output logic                          done,
    output logic [elcr_pkg::QUOT_W-1:0]   quot
);

    localparam int RW = elcr_pkg::ROOT_W;
    localparam int QW = elcr_pkg::QUOT_W;
    localparam int PW = elcr_pkg::PROD_W;
    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [RW-1:0] rem_reg;
    logic [QW-1:0] low_reg;
    logic [RW-1:0] dvs_reg;

    logic [RW:0]   t;
    logic          ge;

    always_comb
    begin
        t  = {rem_reg, low_reg[QW-1]};
        ge = t >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(QW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // the quotient fits in QW bits, so the upper part starts below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RW'(dividend[PW-1:QW]);
            low_reg <= dividend[QW-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? RW'(t - {1'b0, dvs_reg}) : RW'(t);
            low_reg <= {low_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule
